FILE: sv/bdp_pkg.sv
// Shared types and constants for the binary delta patch applier.
// No dependencies; bdp_front, bdp_queue, bdp_back and the top level import it.
package bdp_pkg;

   localparam int OLD_DEPTH   = 65536;
   localparam int OLD_AW      = $clog2(OLD_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [32:0] OLD_DEPTH_W = 33'(OLD_DEPTH);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_RECORD = 2'd1,
      OP_PATCH  = 2'd2,
      OP_BAD    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DIFF_OVR   = 2'd1,
      ST_EXTRA_OVR  = 2'd2,
      ST_UNEXPECTED = 2'd3
   } status_type;

   typedef enum logic {
      CSR_OLD_SIZE = 1'b0,
      CSR_NEW_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_READ = 2'd1,
      KIND_PASS = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [OLD_AW-1:0]   addr;
      logic [7:0]          data;
      logic [23:0]         index;
      status_type          status;
      logic                last;
   } entry_type;

   typedef struct packed {
      logic error;
      logic record_open;
   } front_stat_type;

endpackage

FILE: sv/bdp_req_if.sv
// Input channel: valid/ready plus one patch stream item.
// Depends on nothing.
interface bdp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [15:0]        old_address;
   logic [7:0]         old_data;
   logic [23:0]        diff_length;
   logic [23:0]        extra_length;
   logic signed [31:0] seek_offset;
   logic [7:0]         patch_byte;

   modport source (output valid, operation, old_address, old_data, diff_length,
                   extra_length, seek_offset, patch_byte, input ready);
   modport sink (input valid, operation, old_address, old_data, diff_length,
                 extra_length, seek_offset, patch_byte, output ready);
endinterface

FILE: sv/bdp_rsp_if.sv
// Result channel: valid/ready plus one reconstructed byte.
// Depends on nothing.
interface bdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  new_byte;
   logic [23:0] new_index;
   logic [1:0]  status;
   logic        last_byte;

   modport source (output valid, new_byte, new_index, status, last_byte,
                   input ready);
   modport sink (input valid, new_byte, new_index, status, last_byte,
                 output ready);
endinterface

FILE: sv/bdp_csr_if.sv
// Register write channel: valid/ready, register index and data.
// Depends on nothing.
interface bdp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/bdp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone.
module bdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bdp_front.sv
// Front end: takes items, keeps stream position state, classifies each beat.
// Uses bdp_pkg and the req/csr channel interfaces.
module bdp_front import bdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   bdp_req_if.sink        req,
   bdp_csr_if.sink        csr,
   input  logic           q_full,
   output logic           push,
   output entry_type      push_entry,
   output front_stat_type stat
);

   logic [16:0] old_size_ff, old_size_in;
   logic [23:0] new_size_ff, new_size_in;
   logic [23:0] new_pos_ff, new_pos_in;
   logic [31:0] old_pos_ff, old_pos_in;
   logic [23:0] diff_left_ff, diff_left_in;
   logic [23:0] extra_left_ff, extra_left_in;
   logic [31:0] seek_ff, seek_in;
   logic        error_ff, error_in;

   logic        accept;
   logic        record_open;
   logic [24:0] sum_d;
   logic [25:0] sum_de;
   logic        in_range;
   logic        closing;
   logic        step_diff;
   logic        is_last;

   assign req.ready = !q_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign record_open = (diff_left_ff != '0) || (extra_left_ff != '0);
   assign sum_d       = 25'(new_pos_ff) + 25'(req.diff_length);
   assign sum_de      = 26'(sum_d) + 26'(req.extra_length);
   assign in_range    = (33'(old_pos_ff) < 33'(old_size_ff)) &&
                        (33'(old_pos_ff) < OLD_DEPTH_W);
   assign is_last     = (25'(new_pos_ff) + 25'd1) == 25'(new_size_ff);

   always_comb begin
      old_size_in   = old_size_ff;
      new_size_in   = new_size_ff;
      new_pos_in    = new_pos_ff;
      old_pos_in    = old_pos_ff;
      diff_left_in  = diff_left_ff;
      extra_left_in = extra_left_ff;
      seek_in       = seek_ff;
      error_in      = error_ff;
      push          = 1'b0;
      push_entry    = '{kind: KIND_PASS, addr: '0, data: 8'h00,
                        index: new_pos_ff, status: ST_UNEXPECTED, last: 1'b0};
      closing       = 1'b0;
      step_diff     = 1'b0;

      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_OLD_SIZE: old_size_in = csr.data[16:0];
            CSR_NEW_SIZE: new_size_in = csr.data;
            default: ;
         endcase
      end

      if (accept) begin
         case (op_type'(req.operation))
            OP_LOAD: begin
               if (33'(req.old_address) < OLD_DEPTH_W) begin
                  push            = 1'b1;
                  push_entry.kind = KIND_LOAD;
                  push_entry.addr = OLD_AW'(req.old_address);
                  push_entry.data = req.old_data;
               end
            end
            OP_RECORD: begin
               if (error_ff || record_open || (new_pos_ff >= new_size_ff)) begin
                  push = 1'b1;
               end else if (sum_d > 25'(new_size_ff)) begin
                  push              = 1'b1;
                  push_entry.status = ST_DIFF_OVR;
               end else if (sum_de > 26'(new_size_ff)) begin
                  push              = 1'b1;
                  push_entry.status = ST_EXTRA_OVR;
               end else begin
                  diff_left_in  = req.diff_length;
                  extra_left_in = req.extra_length;
                  if (req.diff_length == '0 && req.extra_length == '0) begin
                     old_pos_in = old_pos_ff + 32'(req.seek_offset);
                  end else begin
                     seek_in = 32'(req.seek_offset);
                  end
               end
               error_in = error_ff || push;
            end
            OP_PATCH: begin
               push = 1'b1;
               if (error_ff || !record_open) begin
                  error_in = 1'b1;
               end else begin
                  push_entry.status = ST_OK;
                  push_entry.data   = req.patch_byte;
                  push_entry.last   = is_last;
                  new_pos_in        = new_pos_ff + 24'd1;
                  if (diff_left_ff != '0) begin
                     step_diff    = 1'b1;
                     diff_left_in = diff_left_ff - 24'd1;
                     closing      = (diff_left_ff == 24'd1) && (extra_left_ff == '0);
                     if (in_range) begin
                        push_entry.kind = KIND_READ;
                        push_entry.addr = OLD_AW'(old_pos_ff);
                     end
                  end else begin
                     extra_left_in = extra_left_ff - 24'd1;
                     closing       = extra_left_ff == 24'd1;
                  end
                  old_pos_in = old_pos_ff + (closing ? seek_ff : 32'd0) +
                               32'(step_diff);
                  if (closing) begin
                     seek_in = '0;
                  end
               end
            end
            default: begin
               push     = 1'b1;
               error_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_size_ff   <= '0;
         new_size_ff   <= '0;
         new_pos_ff    <= '0;
         old_pos_ff    <= '0;
         diff_left_ff  <= '0;
         extra_left_ff <= '0;
         seek_ff       <= '0;
         error_ff      <= 1'b0;
      end else begin
         old_size_ff   <= old_size_in;
         new_size_ff   <= new_size_in;
         new_pos_ff    <= new_pos_in;
         old_pos_ff    <= old_pos_in;
         diff_left_ff  <= diff_left_in;
         extra_left_ff <= extra_left_in;
         seek_ff       <= seek_in;
         error_ff      <= error_in;
      end
   end

   assign stat = '{error: error_ff, record_open: record_open};

endmodule

FILE: sv/bdp_queue.sv
// Short FIFO of classified beats between front and back end.
// Uses bdp_pkg.
module bdp_queue import bdp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type head
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      end
   end

endmodule

FILE: sv/bdp_back.sv
// Back end: old image store, read stage and output register.
// Uses bdp_pkg, bdp_ram and the rsp channel interface.
module bdp_back import bdp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type head,
   output logic      pop,
   bdp_rsp_if.source rsp
);

   logic        s1_valid_ff, s1_valid_in;
   entry_type   s1_ff;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [23:0] out_index_ff;
   status_type  out_status_ff;
   logic        out_last_ff;

   logic       s1_adv;
   logic       s1_load;
   logic [7:0] ram_q;

   assign s1_adv  = !out_valid_ff || rsp.ready;
   assign s1_load = !s1_valid_ff || s1_adv;
   assign pop     = q_valid && s1_load;

   bdp_ram #(.WIDTH(8), .DEPTH(OLD_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (pop && head.kind == KIND_LOAD),
      .wr_addr (head.addr),
      .wr_data (head.data),
      .rd_en   (pop && head.kind == KIND_READ),
      .rd_addr (head.addr),
      .rd_data (ram_q)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (s1_load) begin
         s1_valid_in = pop && head.kind != KIND_LOAD;
      end
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= head;
      end
      if (s1_adv) begin
         out_byte_ff   <= s1_ff.data ^ ((s1_ff.kind == KIND_READ) ? ram_q : 8'h00);
         out_index_ff  <= s1_ff.index;
         out_status_ff <= s1_ff.status;
         out_last_ff   <= s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.new_byte  = out_byte_ff;
   assign rsp.new_index = out_index_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.last_byte = out_last_ff;

endmodule

FILE: sv/binary_delta_patch_apply.sv
// Binary delta patch applier (XOR diff), top level.
// Uses bdp_pkg, the channel interfaces, bdp_front, bdp_queue and bdp_back.
//
//   channel   dir  beat
//   req_chan  in   load byte / control record / patch byte
//   rsp_chan  out  new image byte or error status
//   csr_chan  in   register write (0 old_size, 1 new_size)
//
// One item per cycle sustained while rsp_chan takes its beats. A patch byte
// passes a queue slot, then the store read stage and the output register.
// Reset clears position, length, seek and error state; the old image store
// is not cleared and must be loaded before it is read.
// req_chan stalls only when the four-entry queue is full; csr_chan never stalls.
module binary_delta_patch_apply import bdp_pkg::*; (
   input logic       clock,
   input logic       reset,
   bdp_req_if.sink   req_chan,
   bdp_rsp_if.source rsp_chan,
   bdp_csr_if.sink   csr_chan
);

   logic           push;
   entry_type      push_entry;
   logic           q_full;
   logic           q_valid;
   entry_type      q_head;
   logic           pop;
   front_stat_type stat;

   bdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry),
      .stat       (stat)
   );

   bdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   bdp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .head    (q_head),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      stat.error |=> stat.error)
      else $error("error flag cleared without reset");

   a_fail_has_error: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_OK |-> stat.error)
      else $error("error beat delivered with error flag clear");

   a_orphan_patch: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.operation == OP_PATCH &&
      !stat.record_open |=> stat.error)
      else $error("patch byte outside a record did not raise error");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_byte |-> rsp_chan.status == ST_OK)
      else $error("last byte flagged on an error beat");

endmodule
